/* hw/rtl/lsw_pkg.sv */
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared widths, item kind codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lsw_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned SECTION_W = 3;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [KIND_W-1:0] KIND_RECORD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REGISTER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd4;

  typedef struct packed {
    logic accept;
    logic exec;
    logic q_start;
    logic div_step;
    logic cand_rd;
    logic cand_lat;
    logic scan;
    logic eval;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic known;
    logic div_last;
    logic fill_zero;
    logic scan_last;
    logic cand_last;
  } sts_t;

endpackage

/* hw/rtl/lsw_ctrl.sv */
// ----------------------------------------------------------------------------
// lsw_ctrl
// Sequencer for request decode, update, division and percentile selection.
// ----------------------------------------------------------------------------
module lsw_ctrl import lsw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EXEC   = 4'd1;
  localparam logic [3:0] ST_QSTART = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_CAND   = 4'd4;
  localparam logic [3:0] ST_CLAT   = 4'd5;
  localparam logic [3:0] ST_SCAN   = 4'd6;
  localparam logic [3:0] ST_EVAL   = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_query) begin
          state_d = ST_QSTART;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_QSTART: begin
        cmd_o.q_start = 1'b1;
        state_d       = sts_i.known ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = sts_i.fill_zero ? ST_OUT : ST_CAND;
        end
      end
      ST_CAND: begin
        cmd_o.cand_rd = 1'b1;
        state_d       = ST_CLAT;
      end
      ST_CLAT: begin
        cmd_o.cand_lat = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.cand_last ? ST_OUT : ST_CAND;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/lsw_dp.sv */
// ----------------------------------------------------------------------------
// lsw_dp
// Section records, window memory, serial divider and rank selection logic.
// ----------------------------------------------------------------------------
module lsw_dp import lsw_pkg::*; #(
  parameter int unsigned SECTIONS = 8,
  parameter int unsigned WINDOW   = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [SECTION_W-1:0] section_i,
  input  logic [SAMPLE_W-1:0]  sample_us_i,
  output logic                 status_o,
  output logic [31:0]          sample_count_o,
  output logic [SAMPLE_W-1:0]  min_us_o,
  output logic [SAMPLE_W-1:0]  max_us_o,
  output logic [SUM_W-1:0]     total_us_o,
  output logic [SAMPLE_W-1:0]  average_us_o,
  output logic [SAMPLE_W-1:0]  p50_us_o,
  output logic [SAMPLE_W-1:0]  p95_us_o,
  output logic [SAMPLE_W-1:0]  p99_us_o
);

  localparam int unsigned SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int unsigned WIN_W  = $clog2(WINDOW);
  localparam int unsigned FW     = WIN_W + 1;
  localparam int unsigned ADDR_W = SEC_W + WIN_W;
  localparam int unsigned DEPTH  = SECTIONS * WINDOW;
  localparam logic [17:0] RECIP  = 18'd167773;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  logic [KIND_W-1:0]   kind_q;
  logic [SEC_W-1:0]    sec_q;
  logic                range_q;
  logic [SAMPLE_W-1:0] smp_q;

  logic [SECTIONS-1:0] live_q;
  logic [31:0]         cnt_q  [SECTIONS];
  logic [SAMPLE_W-1:0] min_q  [SECTIONS];
  logic [SAMPLE_W-1:0] max_q  [SECTIONS];
  logic [SUM_W-1:0]    sum_q  [SECTIONS];
  logic [WIN_W-1:0]    head_q [SECTIONS];
  logic [FW-1:0]       fill_q [SECTIONS];

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] mem_q;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;

  logic [FW-1:0]       qn_q, r50_q, r95_q, r99_q, lt_q, le_q;
  logic [WIN_W-1:0]    ci_q;
  logic [FW-1:0]       sj_q;
  logic [SAMPLE_W-1:0] cv_q;

  logic [31:0]          drem_q;
  logic [SUM_W-1:0]     dquo_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [32:0]          dshift;
  logic                 dbit;
  logic [SUM_W-1:0]     dquo_nx;

  logic known;
  logic [31:0]         cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W:0]      sum_add;
  logic                rec_ok;

  function automatic logic [FW-1:0] rank_of(input logic [6:0] q, input logic [FW-1:0] n);
    logic [16:0] x;
    logic [34:0] p;
    logic [10:0] r;
    x = 17'(q) * 17'(n) + 17'd99;
    p = 35'(x) * 35'(RECIP);
    r = p[34:24];
    if (r == 11'd0) r = 11'd1;
    if (r > 11'(n)) r = 11'(n);
    return FW'(r);
  endfunction

  assign known   = range_q && live_q[sec_q];
  assign cnt_r   = cnt_q[sec_q];
  assign sum_r   = sum_q[sec_q];
  assign rec_ok  = cmd_i.exec && (kind_q == KIND_RECORD) && known;
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(smp_q);

  assign dshift  = {drem_q, dquo_q[SUM_W-1]};
  assign dbit    = (dshift >= {1'b0, cnt_r});
  assign dquo_nx = {dquo_q[SUM_W-2:0], dbit};

  assign sts_o.is_query  = (kind_q == KIND_QUERY);
  assign sts_o.known     = known;
  assign sts_o.div_last  = (dcnt_q == DIV_LAST);
  assign sts_o.fill_zero = (qn_q == '0);
  assign sts_o.scan_last = (sj_q == qn_q);
  assign sts_o.cand_last = ({1'b0, ci_q} + FW'(1)) == qn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      sec_q   <= SEC_W'(section_i);
      range_q <= (32'(section_i) < SECTIONS);
      smp_q   <= sample_us_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      for (int s = 0; s < SECTIONS; s++) begin
        cnt_q[s]  <= '0;
        min_q[s]  <= '0;
        max_q[s]  <= '0;
        sum_q[s]  <= '0;
        head_q[s] <= '0;
        fill_q[s] <= '0;
      end
    end else if (cmd_i.exec) begin
      for (int s = 0; s < SECTIONS; s++) begin
        if ((kind_q == KIND_CLEAR_ALL) ||
            (range_q && sec_q == SEC_W'(s) &&
             ((kind_q == KIND_CLEAR) || (kind_q == KIND_REGISTER && !live_q[s])))) begin
          live_q[s] <= (kind_q == KIND_REGISTER);
          cnt_q[s]  <= '0;
          min_q[s]  <= '0;
          max_q[s]  <= '0;
          sum_q[s]  <= '0;
          head_q[s] <= '0;
          fill_q[s] <= '0;
        end else if (rec_ok && sec_q == SEC_W'(s)) begin
          if (cnt_q[s] == '0) begin
            min_q[s] <= smp_q;
            max_q[s] <= smp_q;
          end else begin
            if (smp_q < min_q[s]) min_q[s] <= smp_q;
            if (smp_q > max_q[s]) max_q[s] <= smp_q;
          end
          if (cnt_q[s] != '1) cnt_q[s] <= cnt_q[s] + 32'd1;
          sum_q[s]  <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          head_q[s] <= head_q[s] + WIN_W'(1);
          if (fill_q[s] != FW'(WINDOW)) fill_q[s] <= fill_q[s] + FW'(1);
        end
      end
    end
  end

  assign rd_en   = cmd_i.cand_rd || cmd_i.cand_lat || (cmd_i.scan && !sts_o.scan_last);
  assign rd_addr = cmd_i.cand_rd  ? {sec_q, ci_q} :
                   cmd_i.cand_lat ? {sec_q, WIN_W'(0)} : {sec_q, sj_q[WIN_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (rec_ok) begin
      mem[{sec_q, head_q[sec_q]}] <= smp_q;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      status_o       <= !known;
      sample_count_o <= known ? cnt_r : '0;
      min_us_o       <= known ? min_q[sec_q] : '0;
      max_us_o       <= known ? max_q[sec_q] : '0;
      total_us_o     <= known ? sum_r : '0;
      average_us_o   <= '0;
      p50_us_o       <= '0;
      p95_us_o       <= '0;
      p99_us_o       <= '0;
      qn_q           <= fill_q[sec_q];
      r50_q          <= rank_of(7'd50, fill_q[sec_q]);
      r95_q          <= rank_of(7'd95, fill_q[sec_q]);
      r99_q          <= rank_of(7'd99, fill_q[sec_q]);
      ci_q           <= '0;
      drem_q         <= '0;
      dquo_q         <= sum_r;
      dcnt_q         <= '0;
    end
    if (cmd_i.div_step) begin
      drem_q <= dbit ? 32'(dshift - {1'b0, cnt_r}) : dshift[31:0];
      dquo_q <= dquo_nx;
      dcnt_q <= dcnt_q + DIV_CNT_W'(1);
      if (sts_o.div_last) begin
        average_us_o <= (cnt_r == '0) ? '0 :
                        (|dquo_nx[SUM_W-1:SAMPLE_W]) ? '1 : dquo_nx[SAMPLE_W-1:0];
      end
    end
    if (cmd_i.cand_lat) begin
      cv_q <= mem_q;
      sj_q <= FW'(1);
      lt_q <= '0;
      le_q <= '0;
    end
    if (cmd_i.scan) begin
      lt_q <= lt_q + FW'(mem_q < cv_q);
      le_q <= le_q + FW'(mem_q <= cv_q);
      if (!sts_o.scan_last) sj_q <= sj_q + FW'(1);
    end
    if (cmd_i.eval) begin
      if (lt_q < r50_q && r50_q <= le_q) p50_us_o <= cv_q;
      if (lt_q < r95_q && r95_q <= le_q) p95_us_o <= cv_q;
      if (lt_q < r99_q && r99_q <= le_q) p99_us_o <= cv_q;
      ci_q <= ci_q + WIN_W'(1);
    end
  end

endmodule

/* hw/rtl/latency_stats_with_window_percentiles.sv */
// ----------------------------------------------------------------------------
// latency_stats_with_window_percentiles
// Per-section latency statistics with trailing-window percentiles.
// ----------------------------------------------------------------------------
// Requests arrive on the in_valid_i/in_ready_o channel: record, query,
// register, clear and clear-all. Only a query produces a result, offered on
// the out_valid_o/out_ready_i channel.
// Record, register, clear and clear-all requests pass through the execute
// state before the next request can be taken. A query passes through decode
// and lookup, then the serial average division, then, if the window holds
// samples, percentile selection over the n filled window slots, in which each
// candidate is ranked by one pass over the single read port of the window
// memory; the result is offered in the cycle after. A query of an unknown
// section offers its result right after lookup.
// One request is handled at a time. While the result waits for out_ready_i
// the block holds it stable and takes no new request; the next request is
// taken in the cycle after the result is accepted.
// Reset clears all section records; window memory contents are never read
// until written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module latency_stats_with_window_percentiles import lsw_pkg::*; #(
  parameter int unsigned SECTIONS = 8,
  parameter int unsigned WINDOW   = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [SECTION_W-1:0] section_i,
  input  logic [SAMPLE_W-1:0]  sample_us_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 status_o,
  output logic [31:0]          sample_count_o,
  output logic [SAMPLE_W-1:0]  min_us_o,
  output logic [SAMPLE_W-1:0]  max_us_o,
  output logic [SUM_W-1:0]     total_us_o,
  output logic [SAMPLE_W-1:0]  average_us_o,
  output logic [SAMPLE_W-1:0]  p50_us_o,
  output logic [SAMPLE_W-1:0]  p95_us_o,
  output logic [SAMPLE_W-1:0]  p99_us_o
);

  cmd_t cmd;
  sts_t sts;

  lsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsw_dp #(
    .SECTIONS (SECTIONS),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .section_i      (section_i),
    .sample_us_i    (sample_us_i),
    .status_o       (status_o),
    .sample_count_o (sample_count_o),
    .min_us_o       (min_us_o),
    .max_us_o       (max_us_o),
    .total_us_o     (total_us_o),
    .average_us_o   (average_us_o),
    .p50_us_o       (p50_us_o),
    .p95_us_o       (p95_us_o),
    .p99_us_o       (p99_us_o)
  );

endmodule

/* hw/rtl/lsw_checker.sv */
// ----------------------------------------------------------------------------
// lsw_checker
// Port-level checks on the query results of the latency statistics block.
// ----------------------------------------------------------------------------
module lsw_checker import lsw_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                status_o,
  input logic [31:0]         sample_count_o,
  input logic [SAMPLE_W-1:0] min_us_o,
  input logic [SAMPLE_W-1:0] max_us_o,
  input logic [SUM_W-1:0]    total_us_o,
  input logic [SAMPLE_W-1:0] average_us_o,
  input logic [SAMPLE_W-1:0] p50_us_o,
  input logic [SAMPLE_W-1:0] p95_us_o,
  input logic [SAMPLE_W-1:0] p99_us_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(p50_us_o) &&
    $stable(average_us_o) && $stable(status_o))
    else $error("Result changed while stalled.");

  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> sample_count_o == '0 && total_us_o == '0 &&
    max_us_o == '0 && average_us_o == '0 && p99_us_o == '0)
    else $error("Unknown section result is not zero.");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> p50_us_o <= p95_us_o && p95_us_o <= p99_us_o)
    else $error("Percentiles out of order.");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o && sample_count_o != '0 |->
    min_us_o <= p50_us_o && p99_us_o <= max_us_o &&
    min_us_o <= average_us_o && average_us_o <= max_us_o)
    else $error("Percentile or average outside min and max.");

endmodule

bind latency_stats_with_window_percentiles lsw_checker u_lsw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .sample_count_o (sample_count_o),
  .min_us_o       (min_us_o),
  .max_us_o       (max_us_o),
  .total_us_o     (total_us_o),
  .average_us_o   (average_us_o),
  .p50_us_o       (p50_us_o),
  .p95_us_o       (p95_us_o),
  .p99_us_o       (p99_us_o)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for latency_stats_with_window_percentiles.
// A table of directed requests covers reset state, the sample extremes,
// every request kind and the unknown-section cases. A random phase then
// mixes records, queries, registers and clears under bursty input and a
// stalling output. Query results are checked against table values or a
// software copy of the per-section statistics and nearest-rank percentiles.
// ----------------------------------------------------------------------------
module tb;
  import lsw_pkg::*;

  localparam int NSEC = 8;
  localparam int WIN = 128;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef struct packed {
    logic        status;
    logic [31:0] cnt;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [47:0] tot;
    logic [31:0] avg;
    logic [31:0] p50;
    logic [31:0] p95;
    logic [31:0] p99;
  } stats_t;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [SECTION_W-1:0] sec;
    logic [31:0]          smp;
    bit                   typed;
    stats_t               want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i = '0;
  logic [SECTION_W-1:0] section_i = '0;
  logic [SAMPLE_W-1:0]  sample_us_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  stats_t               got;

  latency_stats_with_window_percentiles u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .section_i, .sample_us_i,
    .out_valid_o, .out_ready_i,
    .status_o(got.status), .sample_count_o(got.cnt), .min_us_o(got.mn),
    .max_us_o(got.mx), .total_us_o(got.tot), .average_us_o(got.avg),
    .p50_us_o(got.p50), .p95_us_o(got.p95), .p99_us_o(got.p99)
  );

  bit          live [NSEC];
  logic [31:0] calls [NSEC];
  logic [31:0] lo [NSEC];
  logic [31:0] hi [NSEC];
  logic [47:0] sum [NSEC];
  logic [31:0] window [NSEC][WIN];
  int          head [NSEC];
  int          fill [NSEC];

  stats_t      pending_stats [$];
  int          errors = 0;
  int          queries_done = 0;
  int          requests_sent = 0;
  int          burst_left = 1;
  longint      cycles = 0;
  bit          holdoff_done = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void wipe(int s);
    live[s] = 1'b0;
    calls[s] = '0;
    lo[s] = '0;
    hi[s] = '0;
    sum[s] = '0;
    head[s] = 0;
    fill[s] = 0;
  endfunction

  function automatic logic [31:0] nearest_rank(ref logic [31:0] srt[$], input int q);
    int n;
    int r;
    n = srt.size();
    r = (q * n + 99) / 100;
    if (r < 1) r = 1;
    if (r > n) r = n;
    return srt[r - 1];
  endfunction

  function automatic stats_t section_stats(int s);
    stats_t r;
    logic [31:0] srt[$];
    logic [47:0] a;
    r = '0;
    if (!live[s]) begin
      r.status = 1'b1;
      return r;
    end
    r.cnt = calls[s];
    r.mn = lo[s];
    r.mx = hi[s];
    r.tot = sum[s];
    if (calls[s] != 0) begin
      a = sum[s] / calls[s];
      r.avg = (a > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
    end
    if (fill[s] > 0) begin
      for (int i = 0; i < fill[s]; i++) srt.push_back(window[s][i]);
      srt.sort();
      r.p50 = nearest_rank(srt, 50);
      r.p95 = nearest_rank(srt, 95);
      r.p99 = nearest_rank(srt, 99);
    end
    return r;
  endfunction

  function automatic void apply_request(row_t rq);
    int s;
    logic [48:0] t;
    s = int'(rq.sec);
    case (rq.kind)
      KIND_RECORD: begin
        if (live[s]) begin
          if (calls[s] == 0) begin
            lo[s] = rq.smp;
            hi[s] = rq.smp;
          end else begin
            if (rq.smp < lo[s]) lo[s] = rq.smp;
            if (rq.smp > hi[s]) hi[s] = rq.smp;
          end
          if (calls[s] != 32'hFFFF_FFFF) calls[s] = calls[s] + 1;
          t = sum[s] + rq.smp;
          sum[s] = t[48] ? 48'hFFFF_FFFF_FFFF : t[47:0];
          window[s][head[s]] = rq.smp;
          head[s] = (head[s] + 1) % WIN;
          if (fill[s] < WIN) fill[s]++;
        end
      end
      KIND_QUERY: begin
        pending_stats.push_back(rq.typed ? rq.want : section_stats(s));
      end
      KIND_REGISTER: begin
        if (!live[s]) begin
          wipe(s);
          live[s] = 1'b1;
        end
      end
      KIND_CLEAR: wipe(s);
      KIND_CLEAR_ALL: begin
        for (int i = 0; i < NSEC; i++) wipe(i);
      end
      default: ;
    endcase
  endfunction

  task automatic offer(row_t rq);
    kind_i <= rq.kind;
    section_i <= rq.sec;
    sample_us_i <= rq.smp;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(rq);
    requests_sent++;
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  function automatic row_t mk(logic [KIND_W-1:0] k, int s, logic [31:0] v);
    row_t r;
    r.kind = k;
    r.sec = SECTION_W'(s);
    r.smp = v;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_exp(int s, stats_t w);
    row_t r;
    r = mk(KIND_QUERY, s, $urandom());
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic row_t random_request();
    int p;
    logic [31:0] v;
    p = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 100);
      1: v = $urandom();
      2: v = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: v = $urandom_range(1000, 5000);
    endcase
    if (p < 70) return mk(KIND_RECORD, $urandom_range(0, 7), v);
    if (p < 82) return mk(KIND_QUERY, $urandom_range(0, 7), v);
    if (p < 90) return mk(KIND_REGISTER, $urandom_range(0, 7), v);
    if (p < 96) return mk(KIND_CLEAR, $urandom_range(0, 7), v);
    if (p < 97) return mk(KIND_CLEAR_ALL, $urandom_range(0, 7), v);
    return mk(3'($urandom_range(5, 7)), $urandom_range(0, 7), v);
  endfunction

  stats_t unknown_stats;
  stats_t empty_stats;
  stats_t one_max;
  row_t   directed [$];

  initial begin
    unknown_stats = '0;
    unknown_stats.status = 1'b1;
    empty_stats = '0;
    one_max = '0;
    one_max.cnt = 1;
    one_max.mn = 32'hFFFF_FFFF;
    one_max.mx = 32'hFFFF_FFFF;
    one_max.tot = 48'h0000_FFFF_FFFF;
    one_max.avg = 32'hFFFF_FFFF;
    one_max.p50 = 32'hFFFF_FFFF;
    one_max.p95 = 32'hFFFF_FFFF;
    one_max.p99 = 32'hFFFF_FFFF;
    for (int i = 0; i < NSEC; i++) wipe(i);

    directed = '{
      mk_exp(0, unknown_stats),
      mk(KIND_RECORD, 0, 32'd5),
      mk(KIND_REGISTER, 0, 32'd0),
      mk_exp(0, empty_stats),
      mk(KIND_REGISTER, 7, 32'd0),
      mk(KIND_RECORD, 7, 32'hFFFF_FFFF),
      mk_exp(7, one_max),
      mk(KIND_REGISTER, 7, 32'd0),
      mk_exp(7, one_max),
      mk(KIND_RECORD, 0, 32'd0),
      mk(KIND_RECORD, 0, 32'hFFFF_FFFF),
      mk(KIND_RECORD, 0, 32'd1),
      mk(KIND_QUERY, 0, 32'd0),
      mk(KIND_CLEAR, 7, 32'd0),
      mk_exp(7, unknown_stats),
      mk(KIND_RECORD, 3, 32'd9),
      mk_exp(3, unknown_stats),
      mk(3'd5, 0, 32'd0),
      mk(3'd6, 0, 32'd0),
      mk(3'd7, 0, 32'd0),
      mk(KIND_QUERY, 0, 32'd0),
      mk(KIND_CLEAR_ALL, 2, 32'd0),
      mk_exp(0, unknown_stats),
      mk(KIND_REGISTER, 2, 32'd0),
      mk_exp(2, empty_stats)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) offer(directed[i]);

    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk_i);
    burst_left = 1;

    // Fill one section past the window length so the write pointer wraps.
    offer(mk(KIND_REGISTER, 5, 32'd0));
    for (int i = 0; i < 140; i++) offer(mk(KIND_RECORD, 5, $urandom()));
    offer(mk(KIND_QUERY, 5, 32'd0));
    offer(mk(KIND_CLEAR, 5, 32'd0));

    for (int i = 0; i < 480; i++) offer(random_request());

    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d requests, checked %0d query results, including a wrapped window.",
             requests_sent, queries_done);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int hold;
    int phase;
    hold = 0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (!holdoff_done && requests_sent > 200) begin
        hold++;
        out_ready_i <= 1'b0;
        if (hold >= 600) holdoff_done = 1'b1;
      end else begin
        phase = (phase + 1) % 23;
        if (phase < 8) out_ready_i <= 1'b1;
        else out_ready_i <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
      end else begin
        if (got !== pending_stats[0]) begin
          $display("%0t: expected %p, actual %p", $realtime, pending_stats[0], got);
          errors++;
        end
        void'(pending_stats.pop_front());
        queries_done++;
      end
    end
  end

endmodule

/* files.f */
hw/rtl/lsw_pkg.sv
hw/rtl/lsw_ctrl.sv
hw/rtl/lsw_dp.sv
hw/rtl/latency_stats_with_window_percentiles.sv
hw/rtl/lsw_checker.sv
tb/tb.sv
